FILE: hdl/tbsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbsc_pkg
// Shared types, codes and helpers of the two-button shutter control.
// ----------------------------------------------------------------------------
package tbsc_pkg;

  localparam int COUNT_W   = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CMD_W     = 2;
  localparam int MODE_W    = 3;

  localparam logic [COUNT_W:0] COUNT_CEILING = (COUNT_W + 1)'(254);

  typedef logic [COUNT_W-1:0] count_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_IDLE      = 3'd0,
    MODE_FULL_UP   = 3'd1,
    MODE_HOLD_UP   = 3'd2,
    MODE_FULL_DOWN = 3'd3,
    MODE_HOLD_DOWN = 3'd4
  } mode_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_NONE = 2'd0,
    CMD_STOP = 2'd1,
    CMD_UP   = 2'd2,
    CMD_DOWN = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START = 2'd0,
    CFG_HOLD  = 2'd1,
    CFG_STOP  = 2'd2,
    CFG_NONE  = 2'd3
  } cfg_idx_t;

  localparam count_t START_TICKS_RST = count_t'(5);
  localparam count_t HOLD_TICKS_RST  = count_t'(40);
  localparam count_t STOP_TICKS_RST  = count_t'(5);

  typedef struct packed {
    count_t start_ticks;
    count_t hold_ticks;
    count_t stop_ticks;
  } cfg_t;

  typedef struct packed {
    count_t press_cnt;
    count_t rel_cnt;
  } key_cnt_t;

  // increment, held at the ceiling
  function automatic count_t sat_inc(input count_t c);
    logic [COUNT_W:0] s;
    s = {1'b0, c} + (COUNT_W + 1)'(1);
    return (s > COUNT_CEILING) ? COUNT_CEILING[COUNT_W-1:0] : s[COUNT_W-1:0];
  endfunction

endpackage

FILE: hdl/tbsc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbsc_if
// Channel interfaces: key samples in, results out, configuration writes.
// ----------------------------------------------------------------------------
interface tbsc_key_if;
  logic valid;
  logic ready;
  logic up_released;
  logic down_released;
  modport source (output valid, output up_released, output down_released, input ready);
  modport sink   (input valid, input up_released, input down_released, output ready);
endinterface

interface tbsc_res_if;
  logic                        valid;
  logic                        ready;
  logic [tbsc_pkg::CMD_W-1:0]  command;
  logic [tbsc_pkg::MODE_W-1:0] motion_mode;
  modport source (output valid, output command, output motion_mode, input ready);
  modport sink   (input valid, input command, input motion_mode, output ready);
endinterface

interface tbsc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tbsc_pkg::CFG_IDX_W-1:0] index;
  logic [tbsc_pkg::COUNT_W-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/tbsc_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbsc_cfg_regs
// Threshold registers, written through the configuration channel.
// ----------------------------------------------------------------------------
module tbsc_cfg_regs (
  input  logic           clk,
  input  logic           rst,
  tbsc_cfg_if.sink       cfg,
  output tbsc_pkg::cfg_t cfg_q
);
  import tbsc_pkg::*;

  cfg_t regs;

  assign cfg.ready = 1'b1;
  assign cfg_q     = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.start_ticks <= START_TICKS_RST;
      regs.hold_ticks  <= HOLD_TICKS_RST;
      regs.stop_ticks  <= STOP_TICKS_RST;
    end else if (cfg.valid) begin
      unique case (cfg_idx_t'(cfg.index))
        CFG_START: regs.start_ticks <= cfg.data;
        CFG_HOLD:  regs.hold_ticks  <= cfg.data;
        CFG_STOP:  regs.stop_ticks  <= cfg.data;
        default:   ;
      endcase
    end
  end

endmodule

FILE: hdl/tbsc_key_eval.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbsc_key_eval
// Rules of one key: start/stop toggle, hold mode entry and hold-mode release.
// ----------------------------------------------------------------------------
module tbsc_key_eval (
  input  logic               released,
  input  logic               dir_down,
  input  tbsc_pkg::cfg_t     cfg_q,
  input  tbsc_pkg::key_cnt_t cnt,
  input  tbsc_pkg::mode_t    mode_in,
  input  tbsc_pkg::cmd_t     cmd_in,
  output tbsc_pkg::key_cnt_t cnt_next,
  output tbsc_pkg::mode_t    mode_out,
  output tbsc_pkg::cmd_t     cmd_out
);
  import tbsc_pkg::*;

  mode_t full_mode;
  mode_t hold_mode;
  cmd_t  drive_cmd;

  assign full_mode = dir_down ? MODE_FULL_DOWN : MODE_FULL_UP;
  assign hold_mode = dir_down ? MODE_HOLD_DOWN : MODE_HOLD_UP;
  assign drive_cmd = dir_down ? CMD_DOWN : CMD_UP;

  always_comb begin
    mode_out = mode_in;
    cmd_out  = cmd_in;
    if (released) begin
      if (mode_in == hold_mode && cnt.rel_cnt == cfg_q.stop_ticks) begin
        mode_out = MODE_IDLE;
        cmd_out  = CMD_STOP;
      end
      cnt_next.press_cnt = '0;
      cnt_next.rel_cnt   = sat_inc(cnt.rel_cnt);
    end else begin
      if (cnt.press_cnt == cfg_q.start_ticks) begin
        if (mode_in != MODE_IDLE) begin
          mode_out = MODE_IDLE;
          cmd_out  = CMD_STOP;
        end else begin
          mode_out = full_mode;
          cmd_out  = drive_cmd;
        end
      end
      // hold wins over the toggle's mode when both thresholds match; the toggle's command stays
      if (cnt.press_cnt == cfg_q.hold_ticks) begin
        mode_out = hold_mode;
      end
      cnt_next.press_cnt = sat_inc(cnt.press_cnt);
      cnt_next.rel_cnt   = '0;
    end
  end

endmodule

FILE: hdl/two_button_shutter_control_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_button_shutter_control_top
// Two-key shutter control: key counters, motion mode and motor command.
// ----------------------------------------------------------------------------
// an accepted key beat passes the input register, then the result register
// throughput: one key beat per cycle while the result side is ready, set by the combinational key logic
//   between the input register and the result register
// reset (rst, synchronous): counters cleared, mode idle, thresholds 5/40/5,
//   both pipeline registers empty
module two_button_shutter_control_top (
  input  logic       clk,
  input  logic       rst,
  tbsc_key_if.sink   key_in,
  tbsc_res_if.source res_out,
  tbsc_cfg_if.sink   cfg
);
  import tbsc_pkg::*;

  cfg_t cfg_q;

  // input register
  logic s1_valid;
  logic s1_up_rel;
  logic s1_down_rel;

  // key state
  key_cnt_t up_cnt;
  key_cnt_t down_cnt;
  mode_t    mode;

  // result register
  logic  res_valid;
  cmd_t  res_cmd;
  mode_t res_mode;

  key_cnt_t up_cnt_next;
  key_cnt_t down_cnt_next;
  mode_t    mode_mid;
  mode_t    mode_next;
  cmd_t     cmd_mid;
  cmd_t     cmd_next;

  logic s2_load;
  logic s1_load;

  tbsc_cfg_regs u_cfg (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .cfg_q (cfg_q)
  );

  tbsc_key_eval u_up (
    .released (s1_up_rel),
    .dir_down (1'b0),
    .cfg_q    (cfg_q),
    .cnt      (up_cnt),
    .mode_in  (mode),
    .cmd_in   (CMD_NONE),
    .cnt_next (up_cnt_next),
    .mode_out (mode_mid),
    .cmd_out  (cmd_mid)
  );

  // down key sees the mode left by the up key
  tbsc_key_eval u_down (
    .released (s1_down_rel),
    .dir_down (1'b1),
    .cfg_q    (cfg_q),
    .cnt      (down_cnt),
    .mode_in  (mode_mid),
    .cmd_in   (cmd_mid),
    .cnt_next (down_cnt_next),
    .mode_out (mode_next),
    .cmd_out  (cmd_next)
  );

  assign s2_load      = s1_valid && (!res_valid || res_out.ready);
  assign s1_load      = key_in.valid && key_in.ready;
  assign key_in.ready = !s1_valid || s2_load;

  assign res_out.valid       = res_valid;
  assign res_out.command     = res_cmd;
  assign res_out.motion_mode = res_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
      up_cnt    <= '0;
      down_cnt  <= '0;
      mode      <= MODE_IDLE;
    end else begin
      if (s1_load) begin
        s1_valid <= 1'b1;
      end else if (s2_load) begin
        s1_valid <= 1'b0;
      end
      if (s2_load) begin
        res_valid <= 1'b1;
        up_cnt    <= up_cnt_next;
        down_cnt  <= down_cnt_next;
        mode      <= mode_next;
      end else if (res_out.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_up_rel   <= key_in.up_released;
      s1_down_rel <= key_in.down_released;
    end
    if (s2_load) begin
      res_cmd  <= cmd_next;
      res_mode <= mode_next;
    end
  end

  // a key never has both counters running
  a_cnt_exclusive: assert property (@(posedge clk) disable iff (rst)
    !((up_cnt.press_cnt != '0 && up_cnt.rel_cnt != '0) ||
      (down_cnt.press_cnt != '0 && down_cnt.rel_cnt != '0)))
    else $error("press and release counters both non-zero");

  a_cnt_ceiling: assert property (@(posedge clk) disable iff (rst)
    {1'b0, up_cnt.press_cnt} <= COUNT_CEILING && {1'b0, up_cnt.rel_cnt} <= COUNT_CEILING &&
    {1'b0, down_cnt.press_cnt} <= COUNT_CEILING &&
    {1'b0, down_cnt.rel_cnt} <= COUNT_CEILING)
    else $error("counter above ceiling");

  a_advance_gives_result: assert property (@(posedge clk) disable iff (rst)
    s2_load |=> res_valid && res_mode == $past(mode_next))
    else $error("advanced item did not reach the result register");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !key_in.ready |-> s1_valid && res_valid && !res_out.ready)
    else $error("input stalled with room in the pipeline");

endmodule

FILE: tb/sv/two_button_shutter_control_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_button_shutter_control_top_tb
// Drives key samples into the shutter control and checks every command and
// mode beat against a cycle-free model of the counters and the motion mode.
// Runs through several threshold settings, from all-zero to the ceiling,
// with random gaps on the key side and random stalls on the result side.
// ----------------------------------------------------------------------------
module two_button_shutter_control_top_tb;
  import tbsc_pkg::*;

  localparam int     PIPE_LATENCY   = 2;
  localparam int     WATCHDOG_LIMIT = 1000;
  localparam count_t CNT_MAX        = COUNT_CEILING[COUNT_W-1:0];

  typedef struct packed {
    logic up_rel;
    logic down_rel;
  } key_sample_t;

  typedef struct {
    cmd_t  command;
    mode_t motion_mode;
  } shutter_result_t;

  logic clk = 1'b0;
  logic rst;

  tbsc_key_if key_if();
  tbsc_res_if res_if();
  tbsc_cfg_if cfg_if();

  two_button_shutter_control_top DUT (
    .clk     (clk),
    .rst     (rst),
    .key_in  (key_if),
    .res_out (res_if),
    .cfg     (cfg_if)
  );

  always #10 clk = ~clk;

  // model state and thresholds
  count_t press_cnt [2];
  count_t rel_cnt   [2];
  mode_t  cur_mode;
  count_t start_thr;
  count_t hold_thr;
  count_t stop_thr;

  key_sample_t     key_q  [$];
  shutter_result_t want_q [$];

  bit quiet;
  int gap_left;
  int stall_left;
  int idle_cycles;
  int n_err;
  int n_keys;
  int n_checked;
  int n_stop;
  int n_up;
  int n_down;
  int n_hold;
  int n_settings;

  function automatic count_t bump(input count_t c);
    return (c >= CNT_MAX) ? CNT_MAX : c + count_t'(1);
  endfunction

  // one key, thresholds compared against the count before this tick
  function automatic cmd_t key_tick(input int k, input logic released,
                                    input mode_t full_m, input mode_t hold_m,
                                    input cmd_t drive, input cmd_t cmd_in);
    cmd_t c;
    c = cmd_in;
    if (released) begin
      if (cur_mode == hold_m && rel_cnt[k] == stop_thr) begin
        cur_mode = MODE_IDLE;
        c = CMD_STOP;
      end
      press_cnt[k] = '0;
      rel_cnt[k] = bump(rel_cnt[k]);
    end else begin
      if (press_cnt[k] == start_thr) begin
        if (cur_mode != MODE_IDLE) begin
          cur_mode = MODE_IDLE;
          c = CMD_STOP;
        end else begin
          cur_mode = full_m;
          c = drive;
        end
      end
      if (press_cnt[k] == hold_thr) begin
        cur_mode = hold_m;
        n_hold++;
      end
      press_cnt[k] = bump(press_cnt[k]);
      rel_cnt[k] = '0;
    end
    return c;
  endfunction

  // up key first, down key sees the mode the up key left
  function automatic void shutter_tick(input logic up_rel, input logic down_rel);
    shutter_result_t r;
    cmd_t c;
    c = key_tick(0, up_rel, MODE_FULL_UP, MODE_HOLD_UP, CMD_UP, CMD_NONE);
    c = key_tick(1, down_rel, MODE_FULL_DOWN, MODE_HOLD_DOWN, CMD_DOWN, c);
    r.command = c;
    r.motion_mode = cur_mode;
    want_q.push_back(r);
    case (c)
      CMD_STOP: n_stop++;
      CMD_UP:   n_up++;
      CMD_DOWN: n_down++;
      default: ;
    endcase
  endfunction

  // key sample driver
  always @(posedge clk) begin : key_driver
    key_sample_t nxt;
    if (rst) begin
      key_if.valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (key_if.valid && key_if.ready) begin
        shutter_tick(key_if.up_released, key_if.down_released);
        n_keys++;
      end
      if (!key_if.valid || key_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          key_if.valid <= 1'b0;
        end else if (key_q.size() > 0) begin
          nxt = key_q.pop_front();
          key_if.valid <= 1'b1;
          key_if.up_released <= nxt.up_rel;
          key_if.down_released <= nxt.down_rel;
          if (!quiet && $urandom_range(0, 15) == 0) gap_left = $urandom_range(1, 11);
        end else begin
          key_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and checker
  always @(posedge clk) begin : result_monitor
    shutter_result_t w;
    if (rst) begin
      res_if.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (want_q.size() == 0) begin
          $error("result beat with nothing expected: command %0d motion_mode %0d",
                 res_if.command, res_if.motion_mode);
          n_err++;
        end else begin
          w = want_q.pop_front();
          if (res_if.command !== w.command) begin
            $error("command: expected %0d, actual %0d", w.command, res_if.command);
            n_err++;
          end
          if (res_if.motion_mode !== w.motion_mode) begin
            $error("motion_mode: expected %0d, actual %0d", w.motion_mode,
                   res_if.motion_mode);
            n_err++;
          end
          n_checked++;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        stall_left = $urandom_range(0, 10);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // ends the run when no beat moves on any channel for too long
  always @(posedge clk) begin : watchdog
    if ((key_if.valid && key_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                 idle_cycles, want_q.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic write_reg(input cfg_idx_t idx, input count_t val);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    case (idx)
      CFG_START: start_thr = val;
      CFG_HOLD:  hold_thr  = val;
      CFG_STOP:  stop_thr  = val;
      default: ;
    endcase
  endtask

  // waits until every queued sample is sent and every result is back, then lets the pipe settle
  task automatic drain();
    while (key_q.size() != 0 || key_if.valid || want_q.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 1) @(posedge clk);
  endtask

  task automatic apply_setting(input count_t s, input count_t h, input count_t p);
    drain();
    write_reg(CFG_START, s);
    write_reg(CFG_HOLD, h);
    write_reg(CFG_STOP, p);
    n_settings++;
  endtask

  function automatic void queue_ticks(input logic up_rel, input logic down_rel,
                                      input int n);
    key_sample_t k;
    k.up_rel = up_rel;
    k.down_rel = down_rel;
    repeat (n) key_q.push_back(k);
  endfunction

  // lengths clustered just below, on and just past a threshold, plus random short and longer ones
  function automatic int pick_len(input count_t thr);
    int t;
    t = int'(thr);
    case ($urandom_range(0, 5))
      0: return (t > 0) ? t - 1 : 0;
      1: return t;
      2: return t + 1;
      3: return t + 2;
      4: return $urandom_range(1, 12);
      default: return $urandom_range(t + 1, t + 24);
    endcase
  endfunction

  function automatic int press_len();
    if ($urandom_range(0, 3) == 0) return 0;
    return pick_len($urandom_range(0, 1) ? start_thr : hold_thr);
  endfunction

  // press episodes on both keys with random overlap, some raw noise
  function automatic void fill_presses(input int budget);
    key_sample_t k;
    int added, up_off, up_len, dn_off, dn_len, span;
    added = 0;
    while (added < budget) begin
      if ($urandom_range(0, 7) == 0) begin
        span = $urandom_range(1, 16);
        repeat (span) begin
          k = key_sample_t'($urandom_range(0, 3));
          key_q.push_back(k);
        end
      end else begin
        up_off = $urandom_range(0, 8);
        dn_off = $urandom_range(0, 8);
        up_len = press_len();
        dn_len = press_len();
        span = (up_off + up_len > dn_off + dn_len) ? up_off + up_len : dn_off + dn_len;
        span += pick_len(stop_thr) + 1;
        for (int t = 0; t < span; t++) begin
          k.up_rel   = !(t >= up_off && t < up_off + up_len);
          k.down_rel = !(t >= dn_off && t < dn_off + dn_len);
          key_q.push_back(k);
        end
      end
      added += span;
    end
  endfunction

  initial begin : stimulus
    rst = 1'b1;
    key_if.valid = 1'b0;
    key_if.up_released = 1'b1;
    key_if.down_released = 1'b1;
    res_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_START;
    cfg_if.data = '0;
    press_cnt = '{default: '0};
    rel_cnt = '{default: '0};
    cur_mode = MODE_IDLE;
    start_thr = START_TICKS_RST;
    hold_thr = HOLD_TICKS_RST;
    stop_thr = STOP_TICKS_RST;
    quiet = 1'b0;
    idle_cycles = 0;
    n_err = 0;
    n_keys = 0;
    n_checked = 0;
    n_stop = 0;
    n_up = 0;
    n_down = 0;
    n_hold = 0;
    n_settings = 1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset thresholds: start up, stop from the down key, both keys at once
    queue_ticks(1'b1, 1'b1, 2);
    queue_ticks(1'b0, 1'b1, 6);
    queue_ticks(1'b1, 1'b1, 3);
    queue_ticks(1'b1, 1'b0, 6);
    queue_ticks(1'b0, 1'b0, 6);
    queue_ticks(1'b1, 1'b1, 2);
    drain();
    fill_presses(350);

    // all thresholds zero, equal thresholds match on the first press tick
    apply_setting(count_t'(0), count_t'(0), count_t'(0));
    fill_presses(150);

    // start and hold thresholds at the ceiling: saturated press counters match every tick
    apply_setting(CNT_MAX, CNT_MAX, count_t'(1));
    fill_presses(200);

    apply_setting(count_t'(2), count_t'(2), CNT_MAX);
    fill_presses(180);

    apply_setting(count_t'(3), count_t'(9), count_t'(2));
    write_reg(CFG_NONE, count_t'($urandom_range(0, 255)));
    fill_presses(250);

    repeat (2) begin
      apply_setting(count_t'($urandom_range(0, 16)), count_t'($urandom_range(0, 24)),
                    count_t'($urandom_range(0, 12)));
      write_reg(CFG_NONE, count_t'($urandom_range(0, 255)));
      fill_presses(150);
    end

    // last stretch runs with no gaps and no stalls
    quiet = 1'b1;
    apply_setting(count_t'($urandom_range(0, 8)), count_t'($urandom_range(0, 16)),
                  count_t'($urandom_range(0, 8)));
    fill_presses(200);

    drain();
    repeat (2 * PIPE_LATENCY + 4) @(posedge clk);
    if (want_q.size() != 0) begin
      $error("%0d expected results never arrived", want_q.size());
      n_err++;
    end
    $display("%0d key samples over %0d threshold settings, %0d results checked",
             n_keys, n_settings, n_checked);
    $display("commands: %0d stop, %0d drive up, %0d drive down; %0d hold entries",
             n_stop, n_up, n_down, n_hold);
    if (n_err == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/tbsc_pkg.sv
hdl/tbsc_if.sv
hdl/tbsc_cfg_regs.sv
hdl/tbsc_key_eval.sv
hdl/two_button_shutter_control_top.sv
tb/sv/two_button_shutter_control_top_tb.sv
